/* rtl/lcg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_pkg: shared constants and types of the line colour gradient
// Channel widths, packed colour layout and the fixed alpha value.
// ----------------------------------------------------------------------------
package lcg_pkg;

  localparam int unsigned CH_W    = 8;   // bits per colour channel
  localparam int unsigned NUM_CH  = 3;   // red, green, blue
  localparam int unsigned COLOR_W = 32;  // packed RGBA word

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // index 2 is red, 1 green, 0 blue, matching the packed word order
  typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

endpackage
`default_nettype wire

/* rtl/lcg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_if: request and result channels of the line colour gradient
// Valid/ready channels; a request moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface lcg_in_if #(
  parameter int unsigned COORD_BITS = 12
);
  import lcg_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [COORD_BITS:0]  full_dx;
  logic signed [COORD_BITS:0]  full_dy;
  logic [COORD_BITS-1:0]       cur_x;
  logic [COORD_BITS-1:0]       cur_y;
  logic [COORD_BITS-1:0]       end_x;
  logic [COORD_BITS-1:0]       end_y;
  logic [COLOR_W-1:0]          color_start;
  logic [COLOR_W-1:0]          color_end;

  modport source (
    output valid, full_dx, full_dy, cur_x, cur_y, end_x, end_y, color_start, color_end,
    input  ready
  );
  modport sink (
    input  valid, full_dx, full_dy, cur_x, cur_y, end_x, end_y, color_start, color_end,
    output ready
  );
endinterface

interface lcg_out_if;
  import lcg_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;

  modport source (
    output valid, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, pixel_color,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/line_color_gradient_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// line_color_gradient_top: per-pixel colour blend along a line
// Requests on in_i carry the line deltas, the current and end points and two
// packed RGBA colours. Results on out_o carry the blended colour, alpha 0xFF.
// Total length T and remaining length C are truncated square roots; each of
// red, green and blue is floor((start*C + end*(T-C))/T), clamped to 0..255.
// When T is zero the end colour is returned.
// Throughput: one request per cycle while out_o is ready or a stage is empty.
// A request passes the squaring and radicand sum stages, the one-bit-per-stage
// square root (COORD_BITS+1 stages), the product and numerator stages and the
// one-bit-per-stage divider (8 stages).
// Each stage carries its own valid bit; a stage takes new data whenever it is
// empty or the stage after it moves, so requests keep being taken while a
// result waits at out_o and bubbles fill in. No request is lost or repeated
// under a stall. Reset clears all valid bits; the pipeline is then empty.
// ----------------------------------------------------------------------------
module line_color_gradient_top #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lcg_in_if.sink        in_i,
  lcg_out_if.source     out_o
);
  import lcg_pkg::*;

  localparam int unsigned D     = COORD_BITS + 1;    // delta width
  localparam int unsigned RW    = COORD_BITS + 1;    // root width
  localparam int unsigned SQ_W  = 2 * COORD_BITS + 1;
  localparam int unsigned RAD_W = 2 * RW;
  localparam int unsigned REM_W = RW + 3;
  localparam int unsigned PS_W  = CH_W + RW;
  localparam int unsigned NW    = RW + CH_W + 2;     // signed numerator
  localparam int unsigned DR_W  = NW - 1;            // divider remainder
  localparam int unsigned ST_BP = RW + 2;
  localparam int unsigned ST_NM = RW + 3;
  localparam int unsigned ST_DV = RW + 4;
  localparam int unsigned NS    = RW + 4 + CH_W;

  typedef struct packed {
    logic [SQ_W-1:0] dx2;
    logic [SQ_W-1:0] dy2;
    logic [SQ_W-1:0] ex2;
    logic [SQ_W-1:0] ey2;
    rgb_t            cs;
    rgb_t            ce;
  } sq_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [RW-1:0]    root;
  } sqs_t;

  typedef struct packed {
    sqs_t tt;
    sqs_t cc;
    rgb_t cs;
    rgb_t ce;
  } rt_t;

  typedef struct packed {
    logic [NUM_CH-1:0][PS_W-1:0] ps;
    logic [NUM_CH-1:0][NW-1:0]   pe;
    logic [RW-1:0]               t;
    rgb_t                        ce;
  } bp_t;

  typedef struct packed {
    logic [NUM_CH-1:0][NW-1:0] num;
    logic [RW-1:0]             t;
    logic                      zero;
    rgb_t                      ce;
  } nm_t;

  typedef struct packed {
    logic [NUM_CH-1:0][DR_W-1:0] rem;
    logic [NUM_CH-1:0]           lo;
    logic [NUM_CH-1:0]           hi;
    rgb_t                        q;
    logic [RW-1:0]               t;
    logic                        zero;
    rgb_t                        ce;
  } dv_t;

  // one root bit per call
  function automatic sqs_t sqrt_step(sqs_t a);
    sqs_t             r;
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    acc   = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
    trial = {1'b0, a.root, 2'b01};
    r.rad = {a.rad[RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {a.root[RW-2:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {a.root[RW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic rt_t rt_step(rt_t a);
    rt_t r;
    r    = a;
    r.tt = sqrt_step(a.tt);
    r.cc = sqrt_step(a.cc);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake: a stage loads when it is empty or everything after it moves
  // --------------------------------------------------------------------------
  logic [NS-1:0] v_q;
  logic [NS-1:0] vin;
  logic [NS-1:0] rdy;

  assign vin = {v_q[NS-2:0], in_i.valid};

  for (genvar i = 0; i < NS; i++) begin : g_rdy
    assign rdy[i] = out_o.ready || !(&v_q[NS-1:i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) v_q[i] <= vin[i];
      end
    end
  end

  assign in_i.ready  = rdy[0];
  assign out_o.valid = v_q[NS-1];

  // --------------------------------------------------------------------------
  // Squares of the deltas
  // --------------------------------------------------------------------------
  logic signed [D-1:0]   ex_s;
  logic signed [D-1:0]   ey_s;
  logic signed [2*D-1:0] dx2_w;
  logic signed [2*D-1:0] dy2_w;
  logic signed [2*D-1:0] ex2_w;
  logic signed [2*D-1:0] ey2_w;
  sq_t                   sq_d;
  sq_t                   sq_q;

  assign ex_s  = $signed({1'b0, in_i.end_x}) - $signed({1'b0, in_i.cur_x});
  assign ey_s  = $signed({1'b0, in_i.end_y}) - $signed({1'b0, in_i.cur_y});
  assign dx2_w = (2*D)'(in_i.full_dx) * (2*D)'(in_i.full_dx);
  assign dy2_w = (2*D)'(in_i.full_dy) * (2*D)'(in_i.full_dy);
  assign ex2_w = (2*D)'(ex_s) * (2*D)'(ex_s);
  assign ey2_w = (2*D)'(ey_s) * (2*D)'(ey_s);

  always_comb begin
    sq_d.dx2 = dx2_w[SQ_W-1:0];
    sq_d.dy2 = dy2_w[SQ_W-1:0];
    sq_d.ex2 = ex2_w[SQ_W-1:0];
    sq_d.ey2 = ey2_w[SQ_W-1:0];
    sq_d.cs  = in_i.color_start[COLOR_W-1:CH_W];
    sq_d.ce  = in_i.color_end[COLOR_W-1:CH_W];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) sq_q <= sq_d;
  end

  // --------------------------------------------------------------------------
  // Radicand sums, then one root bit per stage
  // --------------------------------------------------------------------------
  rt_t rt_q [RW+1];
  rt_t rt0_d;

  always_comb begin
    rt0_d.tt.rad  = {1'b0, sq_q.dx2} + {1'b0, sq_q.dy2};
    rt0_d.tt.rem  = '0;
    rt0_d.tt.root = '0;
    rt0_d.cc.rad  = {1'b0, sq_q.ex2} + {1'b0, sq_q.ey2};
    rt0_d.cc.rem  = '0;
    rt0_d.cc.root = '0;
    rt0_d.cs      = sq_q.cs;
    rt0_d.ce      = sq_q.ce;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) rt_q[0] <= rt0_d;
  end

  for (genvar j = 1; j <= RW; j++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (rdy[1+j]) rt_q[j] <= rt_step(rt_q[j-1]);
    end
  end

  // --------------------------------------------------------------------------
  // Weighted products: start*C and end*(T-C)
  // --------------------------------------------------------------------------
  bp_t bp_d;
  bp_t bp_q;

  always_comb begin
    logic signed [RW:0]   tc;
    logic signed [NW-1:0] pe_w;
    tc      = $signed({1'b0, rt_q[RW].tt.root}) - $signed({1'b0, rt_q[RW].cc.root});
    bp_d.t  = rt_q[RW].tt.root;
    bp_d.ce = rt_q[RW].ce;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      bp_d.ps[ch] = PS_W'(rt_q[RW].cs[ch]) * PS_W'(rt_q[RW].cc.root);
      pe_w        = NW'($signed({1'b0, rt_q[RW].ce[ch]})) * NW'(tc);
      bp_d.pe[ch] = pe_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_BP]) bp_q <= bp_d;
  end

  // --------------------------------------------------------------------------
  // Numerators
  // --------------------------------------------------------------------------
  nm_t nm_d;
  nm_t nm_q;

  always_comb begin
    nm_d.t    = bp_q.t;
    nm_d.zero = (bp_q.t == '0);
    nm_d.ce   = bp_q.ce;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      nm_d.num[ch] = $signed({2'b00, bp_q.ps[ch]}) + $signed(bp_q.pe[ch]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_NM]) nm_q <= nm_d;
  end

  // --------------------------------------------------------------------------
  // Floored division by T, one quotient bit per stage; clamp flags up front
  // --------------------------------------------------------------------------
  dv_t dv_init;
  dv_t dv_q [CH_W];

  always_comb begin
    logic [DR_W-1:0] lim;
    lim          = DR_W'(nm_q.t) << CH_W;
    dv_init.t    = nm_q.t;
    dv_init.zero = nm_q.zero;
    dv_init.ce   = nm_q.ce;
    dv_init.q    = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      dv_init.rem[ch] = nm_q.num[ch][DR_W-1:0];
      dv_init.lo[ch]  = nm_q.num[ch][NW-1];
      dv_init.hi[ch]  = !nm_q.num[ch][NW-1] && (nm_q.num[ch][DR_W-1:0] >= lim);
    end
  end

  for (genvar j = 0; j < CH_W; j++) begin : g_div
    localparam int unsigned K = CH_W - 1 - j;
    dv_t src;
    dv_t nxt;

    if (j == 0) begin : g_first
      assign src = dv_init;
    end else begin : g_next
      assign src = dv_q[j-1];
    end

    always_comb begin
      logic [DR_W-1:0] dvs;
      dvs = DR_W'(src.t) << K;
      nxt = src;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (src.rem[ch] >= dvs) begin
          nxt.rem[ch]  = src.rem[ch] - dvs;
          nxt.q[ch][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[ST_DV+j]) dv_q[j] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result: clamp and pack
  // --------------------------------------------------------------------------
  rgb_t pix;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (dv_q[CH_W-1].zero) begin
        pix[ch] = dv_q[CH_W-1].ce[ch];
      end else if (dv_q[CH_W-1].lo[ch]) begin
        pix[ch] = '0;
      end else if (dv_q[CH_W-1].hi[ch]) begin
        pix[ch] = '1;
      end else begin
        pix[ch] = dv_q[CH_W-1].q[ch];
      end
    end
  end

  assign out_o.pixel_color = {pix, ALPHA_OPAQUE};

endmodule
`default_nettype wire

/* test/tb_line_color_gradient_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_line_color_gradient_top: self-checking bench of the line colour gradient
// Drives pixel requests through the valid/ready request channel with random
// gaps. Results are compared in order against a local predictor of the
// square-root lengths and the floored, clamped blend. A short directed table
// runs first, then random requests shaped mostly like real line pixels.
// ----------------------------------------------------------------------------
module tb_line_color_gradient_top;
  import lcg_pkg::*;

  localparam int unsigned COORD_BITS = 12;
  localparam int          PIPE_LAT   = COORD_BITS + 13;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          RAND_ITEMS = 1200;
  localparam int          MAX_SHOWN  = 10;
  localparam int          COORD_MAX  = (1 << COORD_BITS) - 1;

  typedef struct packed {
    logic signed [COORD_BITS:0] full_dx;
    logic signed [COORD_BITS:0] full_dy;
    logic [COORD_BITS-1:0]      cur_x;
    logic [COORD_BITS-1:0]      cur_y;
    logic [COORD_BITS-1:0]      end_x;
    logic [COORD_BITS-1:0]      end_y;
    logic [COLOR_W-1:0]         color_start;
    logic [COLOR_W-1:0]         color_end;
  } pixel_req_t;

  typedef struct packed {
    pixel_req_t         req;
    logic               typed;   // take want as given, skip the predictor
    logic [COLOR_W-1:0] want;
  } stim_row_t;

  // 13'h1000 is the most negative delta, -4096
  localparam stim_row_t STIM_TAB [16] = '{
    '{'{13'sd0, 13'sd0, 12'd0, 12'd0, 12'd4095, 12'd4095,
        32'h12345678, 32'h9ABCDEF0}, 1'b1, 32'h9ABCDEFF},
    '{'{13'sd0, 13'sd0, 12'd4095, 12'd4095, 12'd0, 12'd0,
        32'hFFFFFFFF, 32'h00000000}, 1'b1, 32'h000000FF},
    '{'{13'sd4095, 13'sd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
        32'h00000000, 32'hFFFFFF00}, 1'b1, 32'hFFFFFFFF},
    '{'{13'sd3, 13'sd4, 12'd0, 12'd0, 12'd3, 12'd4,
        32'hA1B2C3D4, 32'h11223344}, 1'b1, 32'hA1B2C3FF},
    '{'{13'sd1, 13'sd0, 12'd0, 12'd0, 12'd4095, 12'd4095,
        32'h00000000, 32'hFFFFFFFF}, 1'b1, 32'h000000FF},
    '{'{13'sd1, 13'sd0, 12'd0, 12'd0, 12'd4095, 12'd4095,
        32'hFFFFFF00, 32'h00000000}, 1'b1, 32'hFFFFFFFF},
    '{'{13'h1000, 13'h1000, 12'd77, 12'd300, 12'd77, 12'd300,
        32'hDEADBEEF, 32'h55AA5A00}, 1'b1, 32'h55AA5AFF},
    '{'{-13'sd4095, 13'sd0, 12'd2000, 12'd0, 12'd0, 12'd0,
        32'hFF000000, 32'h00FF0000}, 1'b0, 32'h0},
    '{'{13'sd4095, 13'sd0, 12'd2048, 12'd0, 12'd4095, 12'd0,
        32'h00FF8000, 32'hFF00FF00}, 1'b0, 32'h0},
    '{'{13'sd0, -13'sd4095, 12'd9, 12'd1024, 12'd9, 12'd4095,
        32'h10204000, 32'hF0E0C000}, 1'b0, 32'h0},
    '{'{13'sd200, 13'sd100, 12'd150, 12'd75, 12'd200, 12'd100,
        32'h000000AA, 32'hFFFFFF55}, 1'b0, 32'h0},
    '{'{13'sd2, -13'sd1, 12'd0, 12'd0, 12'd40, 12'd9,
        32'hFF00807F, 32'h00FF8080}, 1'b0, 32'h0},
    '{'{-13'sd4095, -13'sd4095, 12'd4095, 12'd4095, 12'd0, 12'd0,
        32'h0F1E2D3C, 32'hC3B2A190}, 1'b1, 32'h0F1E2DFF},
    '{'{13'sd5, 13'sd5, 12'd1, 12'd2, 12'd1, 12'd2,
        32'h000000FF, 32'h000000FF}, 1'b1, 32'h000000FF},
    '{'{13'sd100, -13'sd37, 12'd10, 12'd20, 12'd60, 12'd40,
        32'h7F7F7F7F, 32'h80808080}, 1'b0, 32'h0},
    '{'{13'sd1, 13'sd1, 12'd4095, 12'd0, 12'd4095, 12'd0,
        32'hFFFFFFFF, 32'h0102037F}, 1'b1, 32'h010203FF}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  lcg_in_if #(.COORD_BITS(COORD_BITS)) in_if ();
  lcg_out_if                           out_if ();

  line_color_gradient_top #(.COORD_BITS(COORD_BITS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  logic [COLOR_W-1:0] pixel_exp_q [$];
  int                 fail_count = 0;
  int                 tx_calm    = 0;
  int                 rx_calm    = 0;

  // Mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint isqrt_floor(longint v);
    longint res;
    longint trial;
    res = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = res | (longint'(1) << b);
      if (trial * trial <= v) res = trial;
    end
    return res;
  endfunction

  // Floor toward minus infinity, then clamp to one channel
  function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] s, logic [CH_W-1:0] e,
                                                  longint t, longint c);
    longint num;
    longint q;
    num = longint'(s) * c + longint'(e) * (t - c);
    q   = num / t;
    if ((num % t != 0) && (num < 0)) q = q - 1;
    if (q < 0) return '0;
    if (q > 255) return '1;
    return CH_W'(q);
  endfunction

  function automatic logic [COLOR_W-1:0] gradient_pixel(pixel_req_t r);
    longint dx;
    longint dy;
    longint ex;
    longint ey;
    longint tot;
    longint rem;
    rgb_t   s_rgb;
    rgb_t   e_rgb;
    rgb_t   o_rgb;
    dx    = longint'(signed'(r.full_dx));
    dy    = longint'(signed'(r.full_dy));
    ex    = longint'(r.end_x) - longint'(r.cur_x);
    ey    = longint'(r.end_y) - longint'(r.cur_y);
    tot   = isqrt_floor(dx * dx + dy * dy);
    rem   = isqrt_floor(ex * ex + ey * ey);
    s_rgb = r.color_start[COLOR_W-1:CH_W];
    e_rgb = r.color_end[COLOR_W-1:CH_W];
    if (tot == 0) return {e_rgb, ALPHA_OPAQUE};
    for (int ch = 0; ch < NUM_CH; ch++) o_rgb[ch] = mix_channel(s_rgb[ch], e_rgb[ch], tot, rem);
    return {o_rgb, ALPHA_OPAQUE};
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Most requests are pixels on a real line; the rest are raw bits,
  // zero-length lines and tiny lines seen from far away
  function automatic pixel_req_t make_random_req();
    pixel_req_t r;
    int         mode;
    int         span;
    int         sx;
    int         sy;
    int         ex;
    int         ey;
    int         k;
    mode          = $urandom_range(0, 9);
    r             = '0;
    r.color_start = $urandom;
    r.color_end   = $urandom;
    if (mode <= 5) begin
      case ($urandom_range(0, 3))
        0:       span = 7;
        1:       span = 63;
        default: span = COORD_MAX;
      endcase
      sx = $urandom_range(0, COORD_MAX);
      sy = $urandom_range(0, COORD_MAX);
      ex = clamp_coord(sx + $urandom_range(0, 2 * span) - span);
      ey = clamp_coord(sy + $urandom_range(0, 2 * span) - span);
      k  = $urandom_range(0, 16);
      r.full_dx = (COORD_BITS + 1)'(ex - sx);
      r.full_dy = (COORD_BITS + 1)'(ey - sy);
      r.cur_x   = COORD_BITS'(sx + (ex - sx) * k / 16);
      r.cur_y   = COORD_BITS'(sy + (ey - sy) * k / 16);
      r.end_x   = COORD_BITS'(ex);
      r.end_y   = COORD_BITS'(ey);
    end else if (mode <= 7) begin
      r.full_dx = (COORD_BITS + 1)'($urandom);
      r.full_dy = (COORD_BITS + 1)'($urandom);
      r.cur_x   = COORD_BITS'($urandom);
      r.cur_y   = COORD_BITS'($urandom);
      r.end_x   = COORD_BITS'($urandom);
      r.end_y   = COORD_BITS'($urandom);
    end else if (mode == 8) begin
      r.cur_x = COORD_BITS'($urandom);
      r.cur_y = COORD_BITS'($urandom);
      if ($urandom_range(0, 1) == 1) begin
        r.full_dx = (COORD_BITS + 1)'($urandom);
        r.full_dy = (COORD_BITS + 1)'($urandom);
        r.end_x   = r.cur_x;
        r.end_y   = r.cur_y;
      end else begin
        r.end_x = COORD_BITS'($urandom);
        r.end_y = COORD_BITS'($urandom);
      end
    end else begin
      r.full_dx = (COORD_BITS + 1)'($urandom_range(0, 6) - 3);
      r.full_dy = (COORD_BITS + 1)'($urandom_range(0, 6) - 3);
      r.cur_x   = COORD_BITS'($urandom);
      r.cur_y   = COORD_BITS'($urandom);
      r.end_x   = COORD_BITS'($urandom);
      r.end_y   = COORD_BITS'($urandom);
    end
    return r;
  endfunction

  task automatic send_request(pixel_req_t r, logic typed, logic [COLOR_W-1:0] want);
    int gap;
    gap = pick_gap(tx_calm);
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid       <= 1'b1;
    in_if.full_dx     <= r.full_dx;
    in_if.full_dy     <= r.full_dy;
    in_if.cur_x       <= r.cur_x;
    in_if.cur_y       <= r.cur_y;
    in_if.end_x       <= r.end_x;
    in_if.end_y       <= r.end_y;
    in_if.color_start <= r.color_start;
    in_if.color_end   <= r.color_end;
    do @(posedge clk_i); while (!in_if.ready);
    pixel_exp_q.push_back(typed ? want : gradient_pixel(r));
  endtask

  task automatic flag_error(string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("ERROR: %s", msg);
  endtask

  initial begin : stimulus
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.full_dx     = '0;
    in_if.full_dy     = '0;
    in_if.cur_x       = '0;
    in_if.cur_y       = '0;
    in_if.end_x       = '0;
    in_if.end_y       = '0;
    in_if.color_start = '0;
    in_if.color_end   = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (STIM_TAB[i]) send_request(STIM_TAB[i].req, STIM_TAB[i].typed, STIM_TAB[i].want);
    repeat (RAND_ITEMS) send_request(make_random_req(), 1'b0, '0);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pixel_exp_q.size() != 0) @(posedge clk_i);
    // hold on a little longer to catch stray results
    repeat (PIPE_LAT + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : result_ready
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = pick_gap(rx_calm);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    logic [COLOR_W-1:0] want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pixel_exp_q.size() == 0) begin
        flag_error($sformatf("result %08h with no request pending", out_if.pixel_color));
      end else begin
        want = pixel_exp_q.pop_front();
        if (out_if.pixel_color !== want)
          flag_error($sformatf("pixel_color expected %08h got %08h", want, out_if.pixel_color));
      end
    end
  end

  // Abort when neither channel has moved for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
